// ===== hw/rtl/lrs_pkg.sv =====
// ----------------------------------------------------------------------------
// lrs_pkg: shared types and constants of the link recovery supervisor
// Register indexes, reset values, counter limits and the recovery cause code.
// ----------------------------------------------------------------------------
`default_nettype none

package lrs_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned TIMER_W    = 17;
    localparam int unsigned MS_W       = 16;
    localparam int unsigned ERR_W      = 8;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
    localparam logic [ERR_W-1:0]   ERR_MAX   = {ERR_W{1'b1}};

    localparam logic [MS_W-1:0]  RST_ERROR_WINDOW  = 16'd5000;
    localparam logic [ERR_W-1:0] RST_ERROR_THRESH  = 8'd3;
    localparam logic [MS_W-1:0]  RST_FORCED_INTVL  = 16'd10000;
    localparam logic [MS_W-1:0]  RST_INACT_TIMEOUT = 16'd2500;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ERROR_WINDOW  = 2'd0,
        REG_ERROR_THRESH  = 2'd1,
        REG_FORCED_INTVL  = 2'd2,
        REG_INACT_TIMEOUT = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        CAUSE_NONE     = 2'd0,
        CAUSE_ERRORS   = 2'd1,
        CAUSE_FORCED   = 2'd2,
        CAUSE_INACTIVE = 2'd3
    } t_cause;

    typedef struct packed {
        logic [MS_W-1:0]  error_window_ms;
        logic [ERR_W-1:0] error_threshold;
        logic [MS_W-1:0]  forced_interval_ms;
        logic [MS_W-1:0]  inactivity_timeout_ms;
    } t_cfg;

endpackage

`default_nettype wire

// ===== hw/rtl/lrs_in_if.sv =====
// ----------------------------------------------------------------------------
// lrs_in_if: tick channel
// One transaction is one millisecond tick with its activity and error marks.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrs_in_if;
    logic valid;
    logic ready;
    logic activity_seen;
    logic error_seen;

    modport source (output valid, output activity_seen, output error_seen, input ready);
    modport sink   (input valid, input activity_seen, input error_seen, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lrs_out_if.sv =====
// ----------------------------------------------------------------------------
// lrs_out_if: result channel
// One transaction per tick: recovery request, its cause and the error count.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrs_out_if;
    logic                       valid;
    logic                       ready;
    logic                       recover;
    lrs_pkg::t_cause            cause;
    logic [lrs_pkg::ERR_W-1:0]  errors_now;

    modport source (output valid, output recover, output cause, output errors_now,
                    input ready);
    modport sink   (input valid, input recover, input cause, input errors_now,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lrs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lrs_cfg_regs: configuration register file
// Four write-only registers loaded through a plain indexed write port.
// ----------------------------------------------------------------------------
`default_nettype none

module lrs_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [lrs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [lrs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output lrs_pkg::t_cfg                         o_cfg
);

    lrs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.error_window_ms       <= lrs_pkg::RST_ERROR_WINDOW;
            r_cfg.error_threshold       <= lrs_pkg::RST_ERROR_THRESH;
            r_cfg.forced_interval_ms    <= lrs_pkg::RST_FORCED_INTVL;
            r_cfg.inactivity_timeout_ms <= lrs_pkg::RST_INACT_TIMEOUT;
        end else if (i_cfg_we) begin
            case (lrs_pkg::t_reg_idx'(i_cfg_idx))
                lrs_pkg::REG_ERROR_WINDOW: begin
                    r_cfg.error_window_ms <= i_cfg_data[lrs_pkg::MS_W-1:0];
                end
                lrs_pkg::REG_ERROR_THRESH: begin
                    r_cfg.error_threshold <= i_cfg_data[lrs_pkg::ERR_W-1:0];
                end
                lrs_pkg::REG_FORCED_INTVL: begin
                    r_cfg.forced_interval_ms <= i_cfg_data[lrs_pkg::MS_W-1:0];
                end
                lrs_pkg::REG_INACT_TIMEOUT: begin
                    r_cfg.inactivity_timeout_ms <= i_cfg_data[lrs_pkg::MS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hw/rtl/lrs_tick_core.sv =====
// ----------------------------------------------------------------------------
// lrs_tick_core: timer and error count state with the per-tick update
// Computes one tick's result from the held state and commits it on accept.
// ----------------------------------------------------------------------------
`default_nettype none

module lrs_tick_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire logic                         i_activity_seen,
    input  wire logic                         i_error_seen,
    input  wire lrs_pkg::t_cfg                i_cfg,
    output logic                              o_recover,
    output lrs_pkg::t_cause                   o_cause,
    output logic [lrs_pkg::ERR_W-1:0]         o_errors_now
);

    logic [lrs_pkg::TIMER_W-1:0] r_since_activity, n_since_activity;
    logic [lrs_pkg::TIMER_W-1:0] r_since_forced,   n_since_forced;
    logic [lrs_pkg::TIMER_W-1:0] r_since_window,   n_since_window;
    logic [lrs_pkg::ERR_W-1:0]   r_error_total,    n_error_total;

    logic [lrs_pkg::TIMER_W-1:0] act_base;
    logic [lrs_pkg::TIMER_W-1:0] act_adv;
    logic [lrs_pkg::TIMER_W-1:0] frc_adv;
    logic [lrs_pkg::TIMER_W-1:0] win_adv;
    logic [lrs_pkg::ERR_W-1:0]   err_inc;
    logic                        win_expired;
    logic [lrs_pkg::ERR_W-1:0]   err_kept;
    logic [lrs_pkg::TIMER_W-1:0] win_kept;
    lrs_pkg::t_cause             cause;

    function automatic logic [lrs_pkg::TIMER_W-1:0] sat_inc(
        input logic [lrs_pkg::TIMER_W-1:0] t
    );
        return (t == lrs_pkg::TIMER_MAX) ? t : t + 1'b1;
    endfunction

    always_comb begin
        act_base = i_activity_seen ? '0 : r_since_activity;
        act_adv  = sat_inc(act_base);
        frc_adv  = sat_inc(r_since_forced);
        win_adv  = sat_inc(r_since_window);
        err_inc  = (i_error_seen && (r_error_total != lrs_pkg::ERR_MAX))
                 ? r_error_total + 1'b1 : r_error_total;

        win_expired = win_adv > {1'b0, i_cfg.error_window_ms};
        err_kept    = win_expired ? '0 : err_inc;
        win_kept    = win_expired ? '0 : win_adv;

        n_since_activity = act_adv;
        n_since_forced   = frc_adv;
        n_since_window   = win_kept;
        n_error_total    = err_kept;

        // Only the highest-priority cause fires, and it clears its own timer.
        if (err_kept >= i_cfg.error_threshold) begin
            cause          = lrs_pkg::CAUSE_ERRORS;
            n_error_total  = '0;
            n_since_window = '0;
        end else if (frc_adv > {1'b0, i_cfg.forced_interval_ms}) begin
            cause          = lrs_pkg::CAUSE_FORCED;
            n_since_forced = '0;
        end else if (act_adv > {1'b0, i_cfg.inactivity_timeout_ms}) begin
            cause            = lrs_pkg::CAUSE_INACTIVE;
            n_since_activity = '0;
        end else begin
            cause = lrs_pkg::CAUSE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since_activity <= '0;
            r_since_forced   <= '0;
            r_since_window   <= '0;
            r_error_total    <= '0;
        end else if (i_accept) begin
            r_since_activity <= n_since_activity;
            r_since_forced   <= n_since_forced;
            r_since_window   <= n_since_window;
            r_error_total    <= n_error_total;
        end
    end

    assign o_recover    = (cause != lrs_pkg::CAUSE_NONE);
    assign o_cause      = cause;
    assign o_errors_now = n_error_total;

endmodule

`default_nettype wire

// ===== hw/rtl/link_recovery_supervisor.sv =====
// ----------------------------------------------------------------------------
// link_recovery_supervisor: watchdog supervisor for a serial link
// Tracks inactivity, forced-interval and error-window timers per tick and
// requests a recovery with a prioritized cause.
// ----------------------------------------------------------------------------
// Each tick transaction yields exactly one result transaction in the cycle after
// it is accepted. A new tick is accepted in every cycle in which the result
// register is empty or its result is being taken, so the sustained rate is one
// tick per clock while results are taken; the timer and error-count update between
// the state registers and the result register is combinational. Configuration
// writes take effect on the next accepted tick and should be issued only while
// no tick is in flight. Reset is synchronous and needs no clearing pass.
`default_nettype none

module link_recovery_supervisor (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [lrs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [lrs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    lrs_in_if.sink                                i_item,
    lrs_out_if.source                             o_res
);

    lrs_pkg::t_cfg               cfg;
    logic                        accept;
    logic                        core_recover;
    lrs_pkg::t_cause             core_cause;
    logic [lrs_pkg::ERR_W-1:0]   core_errors;

    logic                        r_out_valid;
    logic                        r_recover;
    lrs_pkg::t_cause             r_cause;
    logic [lrs_pkg::ERR_W-1:0]   r_errors_now;

    lrs_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign i_item.ready = !r_out_valid || o_res.ready;
    assign accept       = i_item.valid && i_item.ready;

    lrs_tick_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_activity_seen (i_item.activity_seen),
        .i_error_seen    (i_item.error_seen),
        .i_cfg           (cfg),
        .o_recover       (core_recover),
        .o_cause         (core_cause),
        .o_errors_now    (core_errors)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_recover    <= core_recover;
            r_cause      <= core_cause;
            r_errors_now <= core_errors;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.recover    = r_recover;
    assign o_res.cause      = r_cause;
    assign o_res.errors_now = r_errors_now;

endmodule

`default_nettype wire

// ===== hw/rtl/lrs_checker.sv =====
// ----------------------------------------------------------------------------
// lrs_checker: port-level assertions for the link recovery supervisor
// Watches the tick and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lrs_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        i_in_ready,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic                        i_recover,
    input wire logic [1:0]                  i_cause,
    input wire logic [lrs_pkg::ERR_W-1:0]   i_errors_now
);

    // A result left waiting keeps its payload.
    a_hold_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            ($stable(i_recover) && $stable(i_cause) && $stable(i_errors_now)))
        else $error("result payload changed while stalled");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A taken result with no new tick behind it leaves the channel empty.
    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !(i_in_valid && i_in_ready)) |=> !i_out_valid)
        else $error("result appeared without a tick");

    a_recover_matches_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_recover == (i_cause != lrs_pkg::CAUSE_NONE)))
        else $error("recover flag disagrees with cause");

    a_threshold_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_cause == lrs_pkg::CAUSE_ERRORS)) |-> (i_errors_now == '0))
        else $error("error count not cleared by threshold recovery");

endmodule

bind link_recovery_supervisor lrs_checker u_lrs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_item.valid),
    .i_in_ready   (i_item.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_recover    (o_res.recover),
    .i_cause      (o_res.cause),
    .i_errors_now (o_res.errors_now)
);

`default_nettype wire
